// ----- rtl/cobs_frame_decoder_macros.svh -----
// Assertion helpers used by the decoder's cfd_step module.
// The module that uses them must have signals named clock and reset.
`ifndef COBS_FRAME_DECODER_MACROS_SVH
`define COBS_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define CFD_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cfd assertion failed");

// Next-cycle implication, also checked across reset.
`define CFD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("cfd assertion failed");

`endif

// ----- rtl/cfd_pkg.sv -----
`timescale 1ns / 1ps

package cfd_pkg;

   localparam int LenWidth = 16;

   localparam int CsrIndexWidth = 1;

   typedef logic [CsrIndexWidth-1:0] csr_index_type;

   localparam csr_index_type CsrDelimiter = 1'b0;
   localparam csr_index_type CsrMaxCode   = 1'b1;

   localparam logic [7:0] DelimiterReset = 8'h00;
   localparam logic [7:0] MaxCodeReset   = 8'hFF;

   typedef struct packed {
      logic [7:0] delimiter;
      logic [7:0] max_code;
   } csr_type;

   typedef struct packed {
      logic [7:0]          out_byte;
      logic                byte_valid;
      logic                frame_end;
      logic [LenWidth-1:0] decoded_length;
   } rsp_type;

endpackage

// ----- rtl/cfd_step.sv -----
`timescale 1ns / 1ps

`include "cobs_frame_decoder_macros.svh"

module cfd_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       enc_byte,
   input  logic             frame_last,
   input  cfd_pkg::csr_type csr,
   output logic             rsp_valid,
   output cfd_pkg::rsp_type rsp
);
   import cfd_pkg::*;

   logic                expect_code_ff, expect_code_in;
   logic [7:0]          code_ff, code_in;
   logic [7:0]          pos_ff, pos_in;
   logic [7:0]          held_byte_ff, held_byte_in;
   logic                held_valid_ff, held_valid_in;
   logic [LenWidth-1:0] count_ff, count_in;

   logic                emit;
   logic [7:0]          emit_byte;
   logic [7:0]          pos_inc;
   logic                have_prev;
   logic [LenWidth-1:0] count_inc;

   assign pos_inc = pos_ff + 8'd1;

   always_comb begin
      emit      = 1'b0;
      emit_byte = 8'h00;
      code_in   = code_ff;
      pos_in    = pos_ff;
      if (expect_code_ff) begin
         code_in = enc_byte;
         pos_in  = 8'h00;
      end else if (code_ff != 8'h00) begin
         if (pos_inc != code_ff) begin
            emit      = 1'b1;
            emit_byte = enc_byte;
            pos_in    = pos_inc;
         end else begin
            if (code_ff < csr.max_code) begin
               emit      = 1'b1;
               emit_byte = csr.delimiter;
            end
            code_in = enc_byte;
            pos_in  = 8'h00;
         end
      end
      if (frame_last) begin
         code_in = 8'h00;
         pos_in  = 8'h00;
      end
   end

   assign have_prev = emit && held_valid_ff;
   assign count_inc = (emit && (count_ff != {LenWidth{1'b1}})) ?
                      count_ff + {{(LenWidth-1){1'b0}}, 1'b1} : count_ff;

   always_comb begin
      rsp.out_byte       = have_prev ? held_byte_ff : 8'h00;
      rsp.byte_valid     = have_prev;
      rsp.frame_end      = frame_last;
      rsp.decoded_length = '0;
      if (frame_last && (count_inc != '0)) begin
         rsp.decoded_length = count_inc - {{(LenWidth-1){1'b0}}, 1'b1};
      end
      rsp_valid = frame_last || have_prev;
   end

   always_comb begin
      expect_code_in = 1'b0;
      held_byte_in   = emit ? emit_byte : held_byte_ff;
      held_valid_in  = held_valid_ff || emit;
      count_in       = count_inc;
      if (frame_last) begin
         expect_code_in = 1'b1;
         held_byte_in   = 8'h00;
         held_valid_in  = 1'b0;
         count_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_code_ff <= 1'b1;
         code_ff        <= 8'h00;
         pos_ff         <= 8'h00;
         held_byte_ff   <= 8'h00;
         held_valid_ff  <= 1'b0;
         count_ff       <= '0;
      end else if (accept) begin
         expect_code_ff <= expect_code_in;
         code_ff        <= code_in;
         pos_ff         <= pos_in;
         held_byte_ff   <= held_byte_in;
         held_valid_ff  <= held_valid_in;
         count_ff       <= count_in;
      end
   end

   `CFD_ASSERT_NEXT(a_reset_clears, reset, expect_code_ff && !held_valid_ff && (count_ff == '0))
   `CFD_ASSERT_SAME(a_pos_below_code, 1'b1, (pos_ff < code_ff) || (pos_ff == 8'h00))
   `CFD_ASSERT_SAME(a_count_held, count_ff != '0, held_valid_ff)
   `CFD_ASSERT_NEXT(a_frame_end_clears, !reset && accept && frame_last,
                    expect_code_ff && !held_valid_ff)

endmodule

// ----- rtl/cfd_out_reg.sv -----
`timescale 1ns / 1ps

module cfd_out_reg (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load_valid,
   input  cfd_pkg::rsp_type             load,
   input  logic                         rsp_stall,
   output logic                         hold,
   output logic                         rsp_valid,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_byte_valid,
   output logic                         rsp_frame_end,
   output logic [cfd_pkg::LenWidth-1:0] rsp_decoded_length
);
   import cfd_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   // hold the upstream while a result waits and the receiver stalls
   assign hold = valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!hold) begin
         valid_ff <= load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold && load_valid) begin
         data_ff <= load;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_byte       = data_ff.out_byte;
   assign rsp_byte_valid     = data_ff.byte_valid;
   assign rsp_frame_end      = data_ff.frame_end;
   assign rsp_decoded_length = data_ff.decoded_length;

endmodule

// ----- rtl/cobs_frame_decoder.sv -----
`timescale 1ns / 1ps

// COBS frame decoder, one encoded byte per transfer.
// Input channel req_*: enc_byte plus frame_last on the frame's last byte.
// A transfer happens at a clock edge with req_valid high and req_stall low.
// Result channel rsp_*: a decoded byte (rsp_byte_valid), and on the last
// byte of a frame a closing result with rsp_frame_end and the decoded length.
// Bytes that produce nothing (codes, swallowed bytes) give no result.
// Every decoded byte is held back one transfer so the phantom final byte can
// be dropped at frame end.
// A result appears on rsp_* in the cycle after its input transfer.
// Throughput: one input byte per cycle while req_stall is low, set by the single output register.
// req_stall rises only while a result waits in the output register and
// rsp_stall is high; an input that produces no result still waits then.
// Configuration csr_*: index 0 delimiter, index 1 max_code; csr_ready is
// always high. Write only while the block is idle.
// Reset (synchronous, active high) restores delimiter 0, max_code 255, and
// clears the frame state and the valid flag of the output register.
module cobs_frame_decoder (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_enc_byte,
   input  logic                         req_frame_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_byte_valid,
   output logic                         rsp_frame_end,
   output logic [cfd_pkg::LenWidth-1:0] rsp_decoded_length,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  cfd_pkg::csr_index_type       csr_index,
   input  logic [7:0]                   csr_data
);
   import cfd_pkg::*;

   csr_type csr_ff;
   logic    accept;
   logic    step_valid;
   rsp_type step_rsp;
   logic    hold;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.delimiter <= DelimiterReset;
         csr_ff.max_code  <= MaxCodeReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CsrDelimiter: begin
               csr_ff.delimiter <= csr_data;
            end
            CsrMaxCode: begin
               csr_ff.max_code <= csr_data;
            end
            default: begin
               csr_ff <= csr_ff;
            end
         endcase
      end
   end

   assign req_stall = hold;
   assign accept    = req_valid && !hold;

   cfd_step u_step (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .enc_byte   (req_enc_byte),
      .frame_last (req_frame_last),
      .csr        (csr_ff),
      .rsp_valid  (step_valid),
      .rsp        (step_rsp)
   );

   cfd_out_reg u_out_reg (
      .clock              (clock),
      .reset              (reset),
      .load_valid         (step_valid && accept),
      .load               (step_rsp),
      .rsp_stall          (rsp_stall),
      .hold               (hold),
      .rsp_valid          (rsp_valid),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_decoded_length (rsp_decoded_length)
   );

endmodule
